### rtl/name_occurrence_counter_macros.svh
// Assertion macros used by the checker of the name occurrence counter.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef NAME_OCCURRENCE_COUNTER_MACROS_SVH
`define NAME_OCCURRENCE_COUNTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NOC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NOC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/noc_pkg.sv
`timescale 1ns / 1ps

package noc_pkg;

    localparam int NAME_W         = 56;
    localparam int BYTE_W         = 8;
    localparam int NAME_BYTES     = NAME_W / BYTE_W;
    localparam int SLOT_W         = 6;
    localparam int OCC_W          = 16;
    localparam int STATUS_W       = 3;

    localparam int DEF_ENTRIES    = 64;
    localparam int DEF_COUNT_BITS = 16;

    localparam logic FUNC_RECORD  = 1'b0;
    localparam logic FUNC_READ    = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW         = 3'd0,
        ST_HIT         = 3'd1,
        ST_FULL        = 3'd2,
        ST_READ_OK     = 3'd3,
        ST_READ_UNUSED = 3'd4
    } status_t;

endpackage

### rtl/name_occurrence_counter.sv
// Record request: the linear scan reads one table entry per cycle from a single-port-read
// memory and compares each entry once its read data is registered; the result strobe follows
// the matching compare, or the end of the scan when the name is new or the table is full.
// Read request: the entry read at acceptance gives the result. busy is low in the result cycle.
// The next request can be accepted in the result cycle. Results cannot be stalled.
// Reset empties the table at once.
`timescale 1ns / 1ps

module name_occurrence_counter #(
    parameter int ENTRIES    = noc_pkg::DEF_ENTRIES,
    parameter int COUNT_BITS = noc_pkg::DEF_COUNT_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         func,
    input  logic [noc_pkg::NAME_W-1:0]   name_head,
    input  logic [noc_pkg::NAME_W-1:0]   name_tail,
    input  logic [noc_pkg::SLOT_W-1:0]   entry_index,
    output logic                         busy,
    output logic                         done,
    output logic [noc_pkg::STATUS_W-1:0] status,
    output logic [noc_pkg::SLOT_W-1:0]   slot,
    output logic [noc_pkg::OCC_W-1:0]    occurrences,
    output logic [noc_pkg::NAME_W-1:0]   stored_head,
    output logic [noc_pkg::NAME_W-1:0]   stored_tail
);

    import noc_pkg::*;

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int USED_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W   = (USED_W > SLOT_W) ? USED_W : SLOT_W;
    localparam int ENTRY_W = 2 * NAME_W + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [USED_W-1:0]     USED_FULL = USED_W'(ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ
    } state_t;

    state_t               state_reg, state_next;
    logic [USED_W-1:0]    used_reg, used_next;
    logic [USED_W-1:0]    scan_reg, scan_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]     cmp_addr_reg, cmp_addr_next;
    logic                 read_ok_reg, read_ok_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic                 done_reg, done_next;
    status_t              status_reg, status_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [OCC_W-1:0]     occ_reg, occ_next;
    logic [NAME_W-1:0]    sh_reg, sh_next;
    logic [NAME_W-1:0]    st_reg, st_next;

    logic [NAME_W-1:0]    name_head_reg, name_tail_reg;
    logic [NAME_W-1:0]    trim_head, trim_tail;

    logic                 mem_wr_en;
    logic [IDX_W-1:0]     mem_wr_addr;
    logic [ENTRY_W-1:0]   mem_wr_data;
    logic                 mem_rd_en;
    logic [IDX_W-1:0]     mem_rd_addr;
    logic [ENTRY_W-1:0]   mem_rd_data;

    logic [NAME_W-1:0]    rd_head, rd_tail;
    logic [COUNT_BITS-1:0] rd_count, count_inc;
    logic [CMP_W-1:0]     idx_ext;
    logic                 hit;
    logic                 accept;

    noc_trim u_trim (
        .head_in  (name_head),
        .tail_in  (name_tail),
        .head_out (trim_head),
        .tail_out (trim_tail)
    );

    noc_mem #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign accept    = start && (state_reg == S_IDLE);
    assign rd_head   = mem_rd_data[ENTRY_W-1 -: NAME_W];
    assign rd_tail   = mem_rd_data[COUNT_BITS +: NAME_W];
    assign rd_count  = mem_rd_data[COUNT_BITS-1:0];
    assign count_inc = (rd_count == COUNT_MAX) ? rd_count : rd_count + 1'b1;
    assign idx_ext   = CMP_W'(entry_index);
    assign hit       = cmp_valid_reg && (rd_head == name_head_reg)
                       && (rd_tail == name_tail_reg);

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        scan_next      = scan_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_addr_next  = cmp_addr_reg;
        read_ok_next   = read_ok_reg;
        idx_next       = idx_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        slot_next      = slot_reg;
        occ_next       = occ_reg;
        sh_next        = sh_reg;
        st_next        = st_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = scan_reg[IDX_W-1:0];
        mem_wr_en      = 1'b0;
        mem_wr_addr    = cmp_addr_reg;
        mem_wr_data    = {name_head_reg, name_tail_reg, count_inc};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_READ)
                    begin
                        state_next   = S_READ;
                        idx_next     = entry_index;
                        read_ok_next = idx_ext < CMP_W'(used_reg);
                        mem_rd_en    = 1'b1;
                        mem_rd_addr  = idx_ext[IDX_W-1:0];
                    end
                    else
                    begin
                        state_next     = S_SCAN;
                        scan_next      = '0;
                        cmp_valid_next = 1'b0;
                    end
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    mem_wr_en   = 1'b1;
                    done_next   = 1'b1;
                    status_next = ST_HIT;
                    slot_next   = SLOT_W'(cmp_addr_reg);
                    occ_next    = OCC_W'(count_inc);
                    sh_next     = '0;
                    st_next     = '0;
                    state_next  = S_IDLE;
                end
                else if (scan_reg < used_reg)
                begin
                    // The entry read now is compared in the next cycle.
                    mem_rd_en      = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_addr_next  = scan_reg[IDX_W-1:0];
                    scan_next      = scan_reg + 1'b1;
                end
                else
                begin
                    done_next  = 1'b1;
                    sh_next    = '0;
                    st_next    = '0;
                    state_next = S_IDLE;
                    if (used_reg < USED_FULL)
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = used_reg[IDX_W-1:0];
                        mem_wr_data = {name_head_reg, name_tail_reg, COUNT_BITS'(1)};
                        used_next   = used_reg + 1'b1;
                        status_next = ST_NEW;
                        slot_next   = SLOT_W'(used_reg);
                        occ_next    = OCC_W'(1);
                    end
                    else
                    begin
                        status_next = ST_FULL;
                        slot_next   = '0;
                        occ_next    = '0;
                    end
                end
            end

            S_READ:
            begin
                done_next  = 1'b1;
                slot_next  = idx_reg;
                state_next = S_IDLE;
                if (read_ok_reg)
                begin
                    status_next = ST_READ_OK;
                    occ_next    = OCC_W'(rd_count);
                    sh_next     = rd_head;
                    st_next     = rd_tail;
                end
                else
                begin
                    status_next = ST_READ_UNUSED;
                    occ_next    = '0;
                    sh_next     = '0;
                    st_next     = '0;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            scan_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_addr_reg  <= '0;
            read_ok_reg   <= 1'b0;
            idx_reg       <= '0;
            done_reg      <= 1'b0;
            status_reg    <= ST_NEW;
            slot_reg      <= '0;
            occ_reg       <= '0;
            sh_reg        <= '0;
            st_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            scan_reg      <= scan_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_addr_reg  <= cmp_addr_next;
            read_ok_reg   <= read_ok_next;
            idx_reg       <= idx_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
            slot_reg      <= slot_next;
            occ_reg       <= occ_next;
            sh_reg        <= sh_next;
            st_reg        <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            name_head_reg <= trim_head;
            name_tail_reg <= trim_tail;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign slot        = slot_reg;
    assign occurrences = occ_reg;
    assign stored_head = sh_reg;
    assign stored_tail = st_reg;

endmodule

### rtl/noc_mem.sv
`timescale 1ns / 1ps

module noc_mem #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A read in the same cycle as a write to that address returns the old data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/noc_trim.sv
`timescale 1ns / 1ps

module noc_trim (
    input  logic [noc_pkg::NAME_W-1:0] head_in,
    input  logic [noc_pkg::NAME_W-1:0] tail_in,
    output logic [noc_pkg::NAME_W-1:0] head_out,
    output logic [noc_pkg::NAME_W-1:0] tail_out
);

    import noc_pkg::*;

    logic ended;

    // A name ends at its first zero byte; that byte and everything after it
    // are cleared, across both halves.
    always_comb
    begin
        ended    = 1'b0;
        head_out = head_in;
        tail_out = tail_in;
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            if (head_in[NAME_W-1-BYTE_W*b -: BYTE_W] == '0)
            begin
                ended = 1'b1;
            end
            if (ended)
            begin
                head_out[NAME_W-1-BYTE_W*b -: BYTE_W] = '0;
            end
        end
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            if (tail_in[NAME_W-1-BYTE_W*b -: BYTE_W] == '0)
            begin
                ended = 1'b1;
            end
            if (ended)
            begin
                tail_out[NAME_W-1-BYTE_W*b -: BYTE_W] = '0;
            end
        end
    end

endmodule

### rtl/noc_checker.sv
`timescale 1ns / 1ps
`include "name_occurrence_counter_macros.svh"

module noc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic [noc_pkg::STATUS_W-1:0] status,
    input logic [noc_pkg::SLOT_W-1:0]   slot,
    input logic [noc_pkg::OCC_W-1:0]    occurrences,
    input logic [noc_pkg::NAME_W-1:0]   stored_head,
    input logic [noc_pkg::NAME_W-1:0]   stored_tail
);

    import noc_pkg::*;

    // An accepted request keeps the block busy in the following cycle.
    `NOC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")

    // The block goes idle exactly as it presents a result.
    `NOC_ASSERT_SAME(a_fall_done, $fell(busy), done, "busy fell without a result")
    `NOC_ASSERT_SAME(a_done_idle, done, !busy && $past(busy), "result without finished request")

    // Record results carry no stored name.
    `NOC_ASSERT_SAME(a_record_name, done && (status == ST_NEW || status == ST_HIT || status == ST_FULL), stored_head == '0 && stored_tail == '0, "record result with stored name")

    // A dropped name reports slot and count zero.
    `NOC_ASSERT_SAME(a_full_zero, done && status == ST_FULL, slot == '0 && occurrences == '0, "table full result not zero")

endmodule

bind name_occurrence_counter noc_checker u_noc_checker (.*);
